>>> rtl/lti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lti_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_METHOD      = 3'd0;
  localparam logic [2:0] REG_RHO         = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd2;
  localparam logic [2:0] REG_INIT_X      = 3'd3;
  localparam logic [2:0] REG_INIT_Y      = 3'd4;
  localparam logic [2:0] REG_INIT_Z      = 3'd5;
  localparam logic [2:0] REG_POINT_COUNT = 3'd6;

  // integrator codes
  localparam logic [1:0] METHOD_EULER = 2'd0;
  localparam logic [1:0] METHOD_RK4   = 2'd1;
  localparam logic [1:0] METHOD_ADAMS = 2'd2;

  localparam logic [1:0]  RST_METHOD      = METHOD_RK4;
  localparam logic [30:0] RST_RHO         = 31'd469762048;
  localparam logic [23:0] RST_STEP_SIZE   = 24'd167772;
  localparam logic [31:0] RST_INIT        = 32'd16777216;
  localparam logic [23:0] RST_POINT_COUNT = 24'd10000;

  // past points kept for the multistep method (h0, h1, h2)
  localparam int HISTORY_DEPTH = 3;

  // points needed before the multistep method takes over from Euler
  localparam logic [23:0] ADAMS_WARMUP = 24'd4;

  localparam int DIV_RK4   = 6;
  localparam int DIV_ADAMS = 24;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD, OP_COMMIT
  } op_e;

  typedef enum logic [3:0] {
    SRC_PX, SRC_PY, SRC_PZ, SRC_T0, SRC_T1, SRC_ACC, SRC_DV, SRC_PC,
    SRC_C10, SRC_RHO, SRC_BETA, SRC_STEP, SRC_WGT
  } src_e;

  typedef enum logic [2:0] {
    DST_T0, DST_T1, DST_ACC, DST_DV, DST_QC, DST_NC
  } dst_e;

  typedef enum logic [2:0] {
    PT_P, PT_Q, PT_H0, PT_H1, PT_H2
  } pt_e;

  typedef enum logic [1:0] {
    SH_0, SH_F, SH_F1
  } sh_e;

  typedef enum logic [2:0] {
    MK_END, MK_LOAD, MK_DERIV, MK_ADV, MK_COMB, MK_COMMIT
  } mk_e;

  typedef enum logic [1:0] {
    PRG_LOAD, PRG_EULER, PRG_RK4, PRG_ADAMS
  } prog_e;

  typedef enum logic [1:0] {
    WS_RK4, WS_AB, WS_AM
  } ws_e;

  typedef struct packed {
    mk_e        kind;
    pt_e        pt;
    logic [2:0] slot;
    dst_e       dst;
    sh_e        sh;
    ws_e        ws;
  } macro_t;

  typedef struct packed {
    op_e               op;
    src_e              a;
    src_e              b;
    dst_e              dst;
    logic [1:0]        coord;
    logic [2:0]        slot;
    pt_e               pt;
    sh_e               sh;
    logic              div24;
    logic signed [7:0] wgt;
  } instr_t;

  typedef struct packed {
    logic   issue;
    logic   emit;
    instr_t instr;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

  function automatic macro_t mk_simple(input mk_e kind);
    macro_t m;
    m = '{kind: kind, pt: PT_P, slot: 3'd0, dst: DST_NC, sh: SH_F, ws: WS_RK4};
    return m;
  endfunction

  function automatic macro_t mk_deriv(input pt_e pt, input logic [2:0] slot);
    macro_t m;
    m = mk_simple(MK_DERIV);
    m.pt = pt;
    m.slot = slot;
    return m;
  endfunction

  function automatic macro_t mk_adv(input logic [2:0] slot, input sh_e sh, input dst_e dst);
    macro_t m;
    m = mk_simple(MK_ADV);
    m.slot = slot;
    m.sh = sh;
    m.dst = dst;
    return m;
  endfunction

  function automatic macro_t mk_comb(input ws_e ws, input dst_e dst);
    macro_t m;
    m = mk_simple(MK_COMB);
    m.ws = ws;
    m.dst = dst;
    return m;
  endfunction

  // step programs, one macro operation per entry
  function automatic macro_t macro_f(input prog_e prog, input logic [3:0] idx);
    macro_t m;
    m = mk_simple(MK_END);
    case (prog)
      PRG_LOAD: begin
        if (idx == 4'd0) m = mk_simple(MK_LOAD);
      end
      PRG_EULER: begin
        case (idx)
          4'd0: m = mk_deriv(PT_P, 3'd0);
          4'd1: m = mk_adv(3'd0, SH_F, DST_NC);
          4'd2: m = mk_simple(MK_COMMIT);
          default: m = mk_simple(MK_END);
        endcase
      end
      PRG_RK4: begin
        case (idx)
          4'd0: m = mk_deriv(PT_P, 3'd0);
          4'd1: m = mk_adv(3'd0, SH_F1, DST_QC);
          4'd2: m = mk_deriv(PT_Q, 3'd1);
          4'd3: m = mk_adv(3'd1, SH_F1, DST_QC);
          4'd4: m = mk_deriv(PT_Q, 3'd2);
          4'd5: m = mk_adv(3'd2, SH_F, DST_QC);
          4'd6: m = mk_deriv(PT_Q, 3'd3);
          4'd7: m = mk_comb(WS_RK4, DST_NC);
          4'd8: m = mk_simple(MK_COMMIT);
          default: m = mk_simple(MK_END);
        endcase
      end
      PRG_ADAMS: begin
        case (idx)
          4'd0: m = mk_deriv(PT_P, 3'd0);
          4'd1: m = mk_deriv(PT_H0, 3'd1);
          4'd2: m = mk_deriv(PT_H1, 3'd2);
          4'd3: m = mk_deriv(PT_H2, 3'd3);
          4'd4: m = mk_comb(WS_AB, DST_QC);
          4'd5: m = mk_deriv(PT_Q, 3'd4);
          4'd6: m = mk_comb(WS_AM, DST_NC);
          4'd7: m = mk_simple(MK_COMMIT);
          default: m = mk_simple(MK_END);
        endcase
      end
      default: m = mk_simple(MK_END);
    endcase
    return m;
  endfunction

  function automatic logic [2:0] term_slot(input ws_e ws, input logic [1:0] j);
    logic [2:0] s;
    s = {1'b0, j};
    if (ws == WS_AM) begin
      case (j)
        2'd0: s = 3'd4;
        2'd1: s = 3'd0;
        2'd2: s = 3'd1;
        default: s = 3'd2;
      endcase
    end
    return s;
  endfunction

  function automatic logic signed [7:0] term_wgt(input ws_e ws, input logic [1:0] j);
    logic signed [7:0] w;
    w = 8'sd1;
    case (ws)
      WS_RK4: w = (j == 2'd1 || j == 2'd2) ? 8'sd2 : 8'sd1;
      WS_AB: begin
        case (j)
          2'd0: w = 8'sd55;
          2'd1: w = -8'sd59;
          2'd2: w = 8'sd37;
          default: w = -8'sd9;
        endcase
      end
      WS_AM: begin
        case (j)
          2'd0: w = 8'sd9;
          2'd1: w = 8'sd19;
          2'd2: w = -8'sd5;
          default: w = 8'sd1;
        endcase
      end
      default: w = 8'sd1;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] steps_f(input mk_e kind);
    logic [3:0] n;
    case (kind)
      MK_DERIV: n = 4'd8;
      MK_ADV:   n = 4'd2;
      MK_COMB:  n = 4'd10;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic per_coord(input mk_e kind);
    return (kind == MK_ADV) || (kind == MK_COMB);
  endfunction

  // one datapath operation of a macro operation
  function automatic instr_t micro_f(input macro_t m, input logic [3:0] step,
                                     input logic [1:0] coord);
    instr_t i;
    logic [1:0] j;
    j = 2'((step + 4'd1) >> 1);
    i = '{op: OP_ADD, a: SRC_T0, b: SRC_T0, dst: DST_T0, coord: coord, slot: m.slot,
          pt: m.pt, sh: SH_0, div24: (m.ws != WS_RK4), wgt: 8'sd0};
    case (m.kind)
      MK_LOAD:   i.op = OP_LOAD;
      MK_COMMIT: i.op = OP_COMMIT;
      MK_DERIV: begin
        case (step)
          4'd0: begin i.op = OP_SUB; i.a = SRC_PY; i.b = SRC_PX; end
          4'd1: begin
            i.op = OP_MUL; i.b = SRC_C10; i.dst = DST_DV; i.coord = 2'd0;
          end
          4'd2: begin i.op = OP_SUB; i.a = SRC_RHO; i.b = SRC_PZ; end
          4'd3: begin i.op = OP_MUL; i.a = SRC_PX; i.sh = SH_F; end
          4'd4: begin
            i.op = OP_SUB; i.b = SRC_PY; i.dst = DST_DV; i.coord = 2'd1;
          end
          4'd5: begin i.op = OP_MUL; i.a = SRC_PX; i.b = SRC_PY; i.sh = SH_F; end
          4'd6: begin
            i.op = OP_MUL; i.a = SRC_BETA; i.b = SRC_PZ; i.sh = SH_F; i.dst = DST_T1;
          end
          default: begin
            i.op = OP_SUB; i.b = SRC_T1; i.dst = DST_DV; i.coord = 2'd2;
          end
        endcase
      end
      MK_ADV: begin
        if (step == 4'd0) begin
          i.op = OP_MUL; i.a = SRC_DV; i.b = SRC_STEP; i.sh = m.sh;
        end else begin
          i.a = SRC_PC; i.dst = m.dst;
        end
      end
      MK_COMB: begin
        case (step)
          4'd0, 4'd1, 4'd3, 4'd5: begin
            i.op = OP_MUL; i.a = SRC_DV; i.b = SRC_WGT;
            i.slot = term_slot(m.ws, j); i.wgt = term_wgt(m.ws, j);
            i.dst = (step == 4'd0) ? DST_ACC : DST_T0;
          end
          4'd2, 4'd4, 4'd6: begin i.a = SRC_ACC; i.dst = DST_ACC; end
          4'd7: begin i.op = OP_MUL; i.a = SRC_ACC; i.b = SRC_STEP; i.sh = SH_F; end
          4'd8: i.op = OP_DIV;
          default: begin i.a = SRC_PC; i.dst = m.dst; end
        endcase
      end
      default: i.op = OP_ADD;
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lti_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lti_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          restart_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               last_point_o,
  input  wire logic [1:0]    method_i,
  input  wire logic [23:0]   point_count_i,
  output lti_pkg::cmd_t      cmd_o,
  input  wire lti_pkg::stat_t stat_i
);
  import lti_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  prog_e       prog_q, prog_d;
  logic [3:0]  mpc_q, mpc_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  coord_q, coord_d;
  logic [23:0] emitted_q, emitted_d;
  logic        out_valid_q, out_valid_d;
  logic        last_q, last_d;
  logic        emit;
  macro_t      cur_m;
  mk_e         next_kind;

  assign cur_m     = macro_f(prog_q, mpc_q);
  assign next_kind = macro_f(prog_q, mpc_q + 4'd1).kind;

  assign cmd_o.issue = (state_q == ST_ISSUE);
  assign cmd_o.emit  = emit;
  assign cmd_o.instr = micro_f(cur_m, step_q, coord_q);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign last_point_o = last_q;

  always_comb begin
    state_d     = state_q;
    prog_d      = prog_q;
    mpc_d       = mpc_q;
    step_d      = step_q;
    coord_d     = coord_q;
    emitted_d   = emitted_q;
    last_d      = last_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        mpc_d   = 4'd0;
        step_d  = 4'd0;
        coord_d = 2'd0;
        if (in_valid_i) begin
          if (restart_i) begin
            prog_d    = PRG_LOAD;
            emitted_d = 24'd1;
            state_d   = ST_ISSUE;
          end else if (emitted_q != 24'd0 && emitted_q < point_count_i) begin
            if (method_i == METHOD_RK4) begin
              prog_d = PRG_RK4;
            end else if (method_i == METHOD_ADAMS && emitted_q >= ADAMS_WARMUP) begin
              prog_d = PRG_ADAMS;
            end else begin
              prog_d = PRG_EULER;
            end
            emitted_d = emitted_q + 24'd1;
            state_d   = ST_ISSUE;
          end
          // otherwise drop the beat: nothing to emit
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (stat_i.done) begin
          state_d = ST_ISSUE;
          if (step_q != steps_f(cur_m.kind) - 4'd1) begin
            step_d = step_q + 4'd1;
          end else begin
            step_d = 4'd0;
            if (per_coord(cur_m.kind) && coord_q != 2'd2) begin
              coord_d = coord_q + 2'd1;
            end else begin
              coord_d = 2'd0;
              mpc_d   = mpc_q + 4'd1;
              if (next_kind == MK_END) state_d = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          emit        = 1'b1;
          out_valid_d = 1'b1;
          last_d      = (emitted_q >= point_count_i);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prog_q      <= PRG_LOAD;
      mpc_q       <= 4'd0;
      step_q      <= 4'd0;
      coord_q     <= 2'd0;
      emitted_q   <= 24'd0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      prog_q      <= prog_d;
      mpc_q       <= mpc_d;
      step_q      <= step_d;
      coord_q     <= coord_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lti_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lti_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lti_pkg::cmd_t         cmd_i,
  output lti_pkg::stat_t             stat_o,
  input  wire logic [30:0]           rho_i,
  input  wire logic [23:0]           step_i,
  input  wire logic [31:0]           init_x_i,
  input  wire logic [31:0]           init_y_i,
  input  wire logic [31:0]           init_z_i,
  output logic [DATA_WIDTH-1:0]      pos_x_o,
  output logic [DATA_WIDTH-1:0]      pos_y_o,
  output logic [DATA_WIDTH-1:0]      pos_z_o
);
  import lti_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 1;

  localparam logic [63:0]        VMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic signed [63:0] VMAXS  = VMAX64;
  localparam logic signed [63:0] VMINS  = -VMAXS - 64'sd1;
  localparam logic [W-1:0]       VMAX   = VMAX64[W-1:0];
  localparam logic [W-1:0]       VMIN   = {1'b1, {(W - 1){1'b0}}};
  localparam logic [63:0]        BETA64 = ((64'd8 << F) + 64'd1) / 64'd3;
  localparam logic [W-1:0]       BETA   = (BETA64 > VMAX64) ? VMAX64[W-1:0] : BETA64[W-1:0];
  localparam logic [W-1:0]       C10    = W'(10);
  localparam logic [PW-1:0]      RND_F  = PW'(1) << (F - 1);
  localparam logic [PW-1:0]      RND_F1 = PW'(1) << F;
  // ceil(2^(W+1) / 3): exact floor division by 3 for any W-bit dividend
  localparam logic [W+1:0]       ONE_X  = (W + 2)'(1);
  localparam logic [W+1:0]       RCP_X  = ((ONE_X << (W + 1)) + (W + 2)'(2)) / (W + 2)'(3);
  localparam logic [W-1:0]       RCP3   = RCP_X[W-1:0];
  // divide by 3, then by 2 for RK4 or by 8 for Adams
  localparam int                 QSH_RK4 = W + 2;
  localparam int                 QSH_AD  = W + 4;

  logic [W-1:0] p_q [3];
  logic [W-1:0] q_q [3];
  logic [W-1:0] n_q [3];
  logic [W-1:0] h0_q [3];
  logic [W-1:0] h1_q [3];
  logic [W-1:0] h2_q [3];
  logic [W-1:0] d_q [5][3];
  logic [W-1:0] pt_v [3];
  logic [W-1:0] t0_q, t1_q, acc_q;
  logic [W-1:0] pos_x_q, pos_y_q, pos_z_q;

  instr_t          ins_q;
  logic            busy_q, mstage_q;
  logic [W-1:0]    opa_q, opb_q;
  logic            neg_q;
  logic [2*W-1:0]  prod_q;

  logic [W-1:0]    a_v, b_v, a_mag, b_mag;
  logic [W-1:0]    rho_v, step_v, res;
  logic [W:0]      sum_add, sum_sub;
  logic [PW-1:0]   rsum, rshift, limit;
  logic [W-1:0]    mul_res, div_res, quo_fin;
  logic            done;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + {{(W - 1){1'b0}}, 1'b1}) : v;
  endfunction

  function automatic logic [W-1:0] clamp_init(input logic [31:0] v);
    logic signed [63:0] s;
    s = 64'(signed'(v));
    if (s > VMAXS) return VMAX;
    if (s < VMINS) return VMIN;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] opnd(input src_e s);
    logic [W-1:0] v;
    case (s)
      SRC_PX:   v = pt_v[0];
      SRC_PY:   v = pt_v[1];
      SRC_PZ:   v = pt_v[2];
      SRC_T0:   v = t0_q;
      SRC_T1:   v = t1_q;
      SRC_ACC:  v = acc_q;
      SRC_DV:   v = d_q[cmd_i.instr.slot][cmd_i.instr.coord];
      SRC_PC:   v = p_q[cmd_i.instr.coord];
      SRC_C10:  v = C10;
      SRC_RHO:  v = rho_v;
      SRC_BETA: v = BETA;
      SRC_STEP: v = step_v;
      SRC_WGT:  v = {{(W - 8){cmd_i.instr.wgt[7]}}, cmd_i.instr.wgt};
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    case (cmd_i.instr.pt)
      PT_P:    pt_v = p_q;
      PT_Q:    pt_v = q_q;
      PT_H0:   pt_v = h0_q;
      PT_H1:   pt_v = h1_q;
      PT_H2:   pt_v = h2_q;
      default: pt_v = p_q;
    endcase
  end

  assign rho_v  = ({33'd0, rho_i} > VMAX64) ? VMAX : W'(rho_i);
  assign step_v = ({40'd0, step_i} > VMAX64) ? VMAX : W'(step_i);
  assign a_v    = opnd(cmd_i.instr.a);
  assign b_v    = opnd(cmd_i.instr.b);
  assign a_mag  = mag(a_v);
  assign b_mag  = mag(b_v);

  // saturating add and subtract
  assign sum_add = {opa_q[W-1], opa_q} + {opb_q[W-1], opb_q};
  assign sum_sub = {opa_q[W-1], opa_q} - {opb_q[W-1], opb_q};

  // rounded, shifted and saturated product, with the sign of the operands applied
  always_comb begin
    case (ins_q.sh)
      SH_F: begin
        rsum   = {1'b0, prod_q} + RND_F;
        rshift = rsum >> F;
      end
      SH_F1: begin
        rsum   = {1'b0, prod_q} + RND_F1;
        rshift = rsum >> (F + 1);
      end
      default: begin
        rsum   = {1'b0, prod_q};
        rshift = rsum;
      end
    endcase
    limit = neg_q ? (PW'(VMAX64) + PW'(1)) : PW'(VMAX64);
    if (rshift > limit) begin
      mul_res = neg_q ? VMIN : VMAX;
    end else begin
      mul_res = neg_q ? (~rshift[W-1:0] + {{(W - 1){1'b0}}, 1'b1}) : rshift[W-1:0];
    end
  end

  // division by 6 or 24 through the multiplier: rounded magnitude times the reciprocal of 3
  assign quo_fin = ins_q.div24 ? W'(prod_q >> QSH_AD) : W'(prod_q >> QSH_RK4);
  assign div_res = neg_q ? (~quo_fin + {{(W - 1){1'b0}}, 1'b1}) : quo_fin;

  always_comb begin
    case (ins_q.op)
      OP_MUL, OP_DIV: done = busy_q && mstage_q;
      default:        done = busy_q;
    endcase
    case (ins_q.op)
      OP_ADD:  res = (sum_add[W] ^ sum_add[W-1]) ? (sum_add[W] ? VMIN : VMAX) : sum_add[W-1:0];
      OP_SUB:  res = (sum_sub[W] ^ sum_sub[W-1]) ? (sum_sub[W] ? VMIN : VMAX) : sum_sub[W-1:0];
      OP_MUL:  res = mul_res;
      OP_DIV:  res = div_res;
      default: res = '0;
    endcase
  end

  assign stat_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      mstage_q <= 1'b0;
    end else if (cmd_i.issue) begin
      busy_q   <= 1'b1;
      mstage_q <= 1'b0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      mstage_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      ins_q <= cmd_i.instr;
      case (cmd_i.instr.op)
        OP_MUL: begin
          opa_q <= a_mag;
          opb_q <= b_mag;
          neg_q <= a_v[W-1] ^ b_v[W-1];
        end
        OP_DIV: begin
          opa_q <= a_mag + (cmd_i.instr.div24 ? W'(DIV_ADAMS / 2) : W'(DIV_RK4 / 2));
          opb_q <= RCP3;
          neg_q <= a_v[W-1];
        end
        default: begin
          opa_q <= a_v;
          opb_q <= b_v;
          neg_q <= 1'b0;
        end
      endcase
    end

    if (busy_q && (ins_q.op == OP_MUL || ins_q.op == OP_DIV) && !mstage_q) begin
      prod_q <= opa_q * opb_q;
    end

    if (done) begin
      case (ins_q.op)
        OP_LOAD: begin
          p_q[0] <= clamp_init(init_x_i);
          p_q[1] <= clamp_init(init_y_i);
          p_q[2] <= clamp_init(init_z_i);
        end
        OP_COMMIT: begin
          h2_q <= h1_q;
          h1_q <= h0_q;
          h0_q <= p_q;
          p_q  <= n_q;
        end
        default: begin
          case (ins_q.dst)
            DST_T0:  t0_q <= res;
            DST_T1:  t1_q <= res;
            DST_ACC: acc_q <= res;
            DST_DV:  d_q[ins_q.slot][ins_q.coord] <= res;
            DST_QC:  q_q[ins_q.coord] <= res;
            DST_NC:  n_q[ins_q.coord] <= res;
            default: t0_q <= res;
          endcase
        end
      endcase
    end

    if (cmd_i.emit) begin
      pos_x_q <= p_q[0];
      pos_y_q <= p_q[1];
      pos_z_q <= p_q[2];
    end
  end

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;

endmodule
`default_nettype wire

>>> rtl/lorenz_trajectory_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// Lorenz trajectory generator (sigma 10, beta 8/3) in signed fixed point with
// FRAC_BITS fraction bits. An input beat with restart set loads the initial point
// and emits it; a beat with restart clear advances one step by the configured
// integrator (Euler, RK4, or Adams-Bashforth/Moulton after three Euler steps) and
// emits the new point. Beats before the first restart or after point_count points
// give no output. A controller steps a microprogram over one shared datapath: each
// operation registers its operands and then writes its result; a multiply, and the
// divide by 6 or 24 at the end of a weighted sum (done as a reciprocal multiply),
// also passes through the product register before its result is written. One item
// is worked on at a time, and the next is taken while the last point still waits in
// the output register.
module lorenz_trajectory_integrator #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRAC_BITS     = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_addr_i,
  input  wire logic [31:0]           cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  restart_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0]      pos_x_o,
  output logic [DATA_WIDTH-1:0]      pos_y_o,
  output logic [DATA_WIDTH-1:0]      pos_z_o,
  output logic                       last_point_o
);
  import lti_pkg::*;

  logic [1:0]  method_q;
  logic [30:0] rho_q;
  logic [23:0] step_q;
  logic [31:0] init_x_q, init_y_q, init_z_q;
  logic [23:0] point_count_q;
  cmd_t        cmd;
  stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q      <= RST_METHOD;
      rho_q         <= RST_RHO;
      step_q        <= RST_STEP_SIZE;
      init_x_q      <= RST_INIT;
      init_y_q      <= RST_INIT;
      init_z_q      <= RST_INIT;
      point_count_q <= RST_POINT_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_METHOD:      method_q      <= cfg_wdata_i[1:0];
        REG_RHO:         rho_q         <= cfg_wdata_i[30:0];
        REG_STEP_SIZE:   step_q        <= cfg_wdata_i[23:0];
        REG_INIT_X:      init_x_q      <= cfg_wdata_i;
        REG_INIT_Y:      init_y_q      <= cfg_wdata_i;
        REG_INIT_Z:      init_z_q      <= cfg_wdata_i;
        REG_POINT_COUNT: point_count_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  lti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .restart_i     (restart_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .last_point_o  (last_point_o),
    .method_i      (method_q),
    .point_count_i (point_count_q),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  lti_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .rho_i    (rho_q),
    .step_i   (step_q),
    .init_x_i (init_x_q),
    .init_y_i (init_y_q),
    .init_z_i (init_z_q),
    .pos_x_o  (pos_x_o),
    .pos_y_o  (pos_y_o),
    .pos_z_o  (pos_z_o)
  );

endmodule
`default_nettype wire

>>> rtl/lti_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lti_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  restart_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [DATA_WIDTH-1:0] pos_x_o,
  input wire logic [DATA_WIDTH-1:0] pos_y_o,
  input wire logic [DATA_WIDTH-1:0] pos_z_o,
  input wire logic                  last_point_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({pos_x_o, pos_y_o, pos_z_o, last_point_o}))
    else $error("output payload changed while stalled");

  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && restart_i |=> in_stall_o)
    else $error("restart beat did not start work");

  a_emit_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat appeared without work in progress");

endmodule

bind lorenz_trajectory_integrator lti_checker #(.DATA_WIDTH(DATA_WIDTH)) u_lti_checker (.*);
`default_nettype wire
